FILE: rtl/tpwm_pkg.sv
// Shared types, constants and sine helper for the two-phase sine PWM block.
`default_nettype none

package tpwm_pkg;

    localparam int unsigned SINE_TABLE_DEPTH_DEF = 1024;
    localparam int unsigned SINE_BITS_DEF        = 16;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned ELAPSED_W  = 16;
    localparam int unsigned SPEED_W    = 8;
    localparam int unsigned CMP_W      = 16;
    localparam int unsigned PERIOD_W   = 10;
    localparam int unsigned COUNT_W    = 20;

    localparam logic [15:0] PWM_PERIOD_RST  = 16'd8400;
    localparam logic [9:0]  NOM_PERIOD_RST  = 10'd20;
    localparam logic [9:0]  MIN_PERIOD_RST  = 10'd14;
    localparam logic [9:0]  MAX_PERIOD_RST  = 10'd500;
    localparam logic [6:0]  PHASE_SHIFT_RST = 7'd26;
    localparam logic [9:0]  VOLT_COMP_RST   = 10'd80;
    localparam logic [6:0]  FLOOR_PCT_RST   = 7'd4;
    localparam logic [9:0]  TICKS_MS_RST    = 10'd56;

    localparam int unsigned PCT_SCALE  = 100;
    localparam int unsigned PCT_ROUND  = 50;
    localparam int unsigned PERMILLE   = 1000;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PWM_PERIOD   = 3'd0,
        CFG_NOM_PERIOD   = 3'd1,
        CFG_MIN_PERIOD   = 3'd2,
        CFG_MAX_PERIOD   = 3'd3,
        CFG_PHASE_SHIFT  = 3'd4,
        CFG_VOLT_COMP    = 3'd5,
        CFG_FLOOR_PCT    = 3'd6,
        CFG_TICKS_PER_MS = 3'd7
    } t_cfg_idx;

    typedef enum logic {
        ALU_MUL = 1'b0,
        ALU_DIV = 1'b1
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef struct packed {
        logic done;
    } t_alu_rsp;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SP_MUL1,
        S_SP_MUL2,
        S_SP_MUL3,
        S_SP_DIV,
        S_SP_END,
        S_TK_START,
        S_TK_FULL,
        S_TK_MOD,
        S_TK_FULL2,
        S_TK_IDX,
        S_TK_SH,
        S_TK_FL_MUL,
        S_TK_FL_DIV,
        S_TK_ROM,
        S_TK_AMP_MUL,
        S_TK_AMP_DIV,
        S_TK_C_MUL,
        S_TK_C_DIV,
        S_TK_V_MUL,
        S_TK_V_DIV,
        S_TK_STORE,
        S_DONE
    } t_state;

    // quarter-wave sine in Q30, Taylor series through x^15, scaled to amp
    function automatic logic [63:0] quarter_sine(input logic [63:0] x,
                                                 input logic [63:0] amp);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int k = 1; k <= 7; k++) begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if ((k % 2) == 1) begin
                sum = (term > sum) ? 64'd0 : sum - term;
            end else begin
                sum = sum + term;
            end
        end
        v = (sum * amp + (64'd1 << 29)) >> 30;
        return (v > amp) ? amp : v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/tpwm_in_if.sv
// Input channel: one command word per handshake.
`default_nettype none

interface tpwm_in_if;
    logic                             valid;
    logic                             ready;
    logic                             op;
    logic [tpwm_pkg::ELAPSED_W-1:0]   elapsed_ticks;
    logic [tpwm_pkg::SPEED_W-1:0]     speed_percent;

    modport source (output valid, op, elapsed_ticks, speed_percent, input ready);
    modport sink   (input valid, op, elapsed_ticks, speed_percent, output ready);
endinterface

`default_nettype wire

FILE: rtl/tpwm_out_if.sv
// Output channel: one compare/status word per handshake.
`default_nettype none

interface tpwm_out_if;
    logic                         valid;
    logic                         ready;
    logic [tpwm_pkg::CMP_W-1:0]   phase1_pos;
    logic [tpwm_pkg::CMP_W-1:0]   phase1_neg;
    logic [tpwm_pkg::CMP_W-1:0]   phase2_pos;
    logic [tpwm_pkg::CMP_W-1:0]   phase2_neg;
    logic                         driver_enable;
    logic                         running;

    modport source (output valid, phase1_pos, phase1_neg, phase2_pos, phase2_neg,
                    driver_enable, running, input ready);
    modport sink   (input valid, phase1_pos, phase1_neg, phase2_pos, phase2_neg,
                    driver_enable, running, output ready);
endinterface

`default_nettype wire

FILE: rtl/tpwm_serial_alu.sv
// Shared bit-serial unit: shift-add multiply and restoring divide, one bit per cycle.
`default_nettype none

module tpwm_serial_alu #(
    parameter int unsigned W = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  tpwm_pkg::t_alu_req      i_req,
    input  wire logic [W-1:0]       i_a,
    input  wire logic [W-1:0]       i_b,
    output tpwm_pkg::t_alu_rsp      o_rsp,
    output logic [W-1:0]            o_res,
    output logic [W-1:0]            o_rem
);

    localparam int unsigned CW = $clog2(W + 1);

    logic                r_busy;
    logic                r_done;
    tpwm_pkg::t_alu_op   r_op;
    logic [W-1:0]        r_a;
    logic [W-1:0]        r_b;
    logic [W-1:0]        r_acc;
    logic [W-1:0]        r_rem;
    logic [CW-1:0]       r_cnt;
    logic [W:0]          w_rem_sh;
    logic                w_fit;

    assign w_rem_sh = {r_rem, r_a[W-1]};
    assign w_fit    = (w_rem_sh >= {1'b0, r_b});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_op == tpwm_pkg::ALU_MUL) begin
                    if (r_b == '0) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end else if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op  <= i_req.op;
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
            r_rem <= '0;
            r_cnt <= CW'(W);
        end else if (r_busy) begin
            if (r_op == tpwm_pkg::ALU_MUL) begin
                if (r_b[0]) begin
                    r_acc <= r_acc + r_a;
                end
                r_a <= r_a << 1;
                r_b <= r_b >> 1;
            end else begin
                r_rem <= w_fit ? W'(w_rem_sh - {1'b0, r_b}) : w_rem_sh[W-1:0];
                r_a   <= {r_a[W-2:0], w_fit};
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_res      = (r_op == tpwm_pkg::ALU_MUL) ? r_acc : r_a;
    assign o_rem      = r_rem;

endmodule

`default_nettype wire

FILE: rtl/tpwm_sine_rom.sv
// Quarter-wave sine table with registered read; returns magnitude and sign.
`default_nettype none

module tpwm_sine_rom #(
    parameter int unsigned SINE_TABLE_DEPTH = tpwm_pkg::SINE_TABLE_DEPTH_DEF,
    parameter int unsigned SINE_BITS        = tpwm_pkg::SINE_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic [$clog2(SINE_TABLE_DEPTH)-1:0]   i_idx,
    output logic [SINE_BITS-2:0]                       o_mag,
    output logic                                       o_neg
);

    localparam int unsigned DB = $clog2(SINE_TABLE_DEPTH);
    localparam int unsigned MW = SINE_BITS - 1;
    localparam int unsigned QN = SINE_TABLE_DEPTH / 4;
    localparam int unsigned QW = DB - 1;
    localparam logic [MW-1:0] AMP = {MW{1'b1}};

    logic [MW-1:0] w_tab [QN+1];
    logic [1:0]    w_q;
    logic [DB-3:0] w_k;
    logic [QW-1:0] w_r;
    logic [MW-1:0] r_mag;
    logic          r_neg;

    for (genvar g = 0; g <= QN; g++) begin : g_tab
        localparam logic [63:0] X = (tpwm_pkg::HALF_PI_Q30 * 64'(4 * g))
                                    / 64'(SINE_TABLE_DEPTH);
        assign w_tab[g] = MW'(tpwm_pkg::quarter_sine(X, 64'(AMP)));
    end

    assign w_q = i_idx[DB-1:DB-2];
    assign w_k = i_idx[DB-3:0];
    assign w_r = w_q[0] ? (QW'(QN) - QW'(w_k)) : QW'(w_k);

    always_ff @(posedge i_clk) begin
        r_mag <= w_tab[w_r];
        r_neg <= w_q[1] && (w_tab[w_r] != '0);
    end

    assign o_mag = r_mag;
    assign o_neg = r_neg;

endmodule

`default_nettype wire

FILE: rtl/two_phase_vf_sine_pwm.sv
// Two-phase volts-per-hertz sine PWM generator, top level.
//
// Channels: i_item takes a command word (op 1 = set speed, op 0 = tick with
// elapsed_ticks); o_res returns one word per command: four PWM compare values,
// driver_enable and running. i_cfg_we/i_cfg_idx/i_cfg_data write the eight
// settings registers. The user must write them only while the block is idle;
// the block does not enforce it. All multiplies and divides run through one
// bit-serial multiply/divide unit. A multiply stops once no multiplier bits
// are left; a divide runs through all W bits (W = max(16+SINE_BITS,
// 20+log2(SINE_TABLE_DEPTH)), 32 at default settings). A set-speed word uses
// up to 3 multiplies and 1 divide; a tick uses up to 10 divides among its
// serial steps, none while the wave is off. One word is in work at a time.
// The result sits in an output register; the next command is taken while it
// waits. A stalled receiver holds the result word and blocks completion of
// the following command only.
// Reset (synchronous, active low) restores register defaults, clears period,
// phase count, compare values and enable, and empties the output register.
`default_nettype none

module two_phase_vf_sine_pwm #(
    parameter int unsigned SINE_TABLE_DEPTH = tpwm_pkg::SINE_TABLE_DEPTH_DEF,
    parameter int unsigned SINE_BITS        = tpwm_pkg::SINE_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    tpwm_in_if.sink                                  i_item,
    tpwm_out_if.source                               o_res,
    input  wire logic                                i_cfg_we,
    input  wire logic [tpwm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [tpwm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int unsigned DB = $clog2(SINE_TABLE_DEPTH);
    localparam int unsigned MW = SINE_BITS - 1;
    localparam int unsigned W  = (16 + SINE_BITS > 20 + DB) ? 16 + SINE_BITS : 20 + DB;
    localparam logic [MW-1:0] AMP = {MW{1'b1}};

    tpwm_pkg::t_state   r_state;
    tpwm_pkg::t_state   n_state;

    logic [15:0] r_pwm;
    logic [9:0]  r_nom;
    logic [9:0]  r_min;
    logic [9:0]  r_max;
    logic [6:0]  r_psp;
    logic [9:0]  r_comp;
    logic [6:0]  r_floor;
    logic [9:0]  r_tpm;

    logic [9:0]  r_target;
    logic [9:0]  r_active;
    logic [19:0] r_count;
    logic [15:0] r_cmp [4];
    logic        r_en;

    logic        r_op;
    logic [15:0] r_elapsed;
    logic [7:0]  r_speed;
    logic [20:0] r_cnt;
    logic [19:0] r_full;
    logic [DB-1:0] r_idx1;
    logic [DB-1:0] r_idx2;
    logic [16:0] r_fl;
    logic [W-1:0] r_x;
    logic [17:0] r_y;
    logic [17:0] r_z;
    logic [MW-1:0] r_m;
    logic        r_phase;
    logic        r_neg;
    logic        r_issued;

    logic        r_ov;
    logic [15:0] r_o_cmp [4];
    logic        r_o_en;
    logic        r_o_run;

    tpwm_pkg::t_alu_req w_req;
    tpwm_pkg::t_alu_rsp w_rsp;
    logic [W-1:0] w_a;
    logic [W-1:0] w_b;
    logic [W-1:0] w_res;
    logic [W-1:0] w_rem;

    logic [W-1:0]  w_den_pos;
    logic [W-1:0]  w_num;
    logic          w_sp_skip;
    logic [W-1:0]  w_per1;
    logic [W-1:0]  w_per2;
    logic          w_nowrap;
    logic          w_full0;
    logic [10:0]   w_factor;
    logic [MW-1:0] w_rom_mag;
    logic          w_rom_neg;
    logic [15:0]   w_c;
    logic [15:0]   w_cf;
    logic          w_out_load;

    assign w_den_pos = (W'(r_nom) << 6) + (W'(r_nom) << 5) + (W'(r_nom) << 2) + W'(r_y);
    assign w_num     = (r_x << 6) + (r_x << 5) + (r_x << 2);
    assign w_sp_skip = (w_den_pos <= W'(r_z));
    assign w_per1    = (r_x < W'(r_min)) ? W'(r_min) : r_x;
    assign w_per2    = (w_per1 > W'(r_max)) ? W'(r_max) : w_per1;
    assign w_nowrap  = (r_cnt < 21'(r_full));
    assign w_full0   = (r_full == '0);
    assign w_factor  = r_phase ? ((r_comp >= 10'(tpwm_pkg::PERMILLE)) ? 11'd0
                                  : 11'(tpwm_pkg::PERMILLE) - 11'(r_comp))
                               : 11'(tpwm_pkg::PERMILLE) + 11'(r_comp);
    assign w_c       = (r_x > W'(r_pwm)) ? r_pwm : r_x[15:0];
    assign w_cf      = (17'(w_c) < r_fl) ? 16'd0 : w_c;
    assign w_out_load = (r_state == tpwm_pkg::S_DONE) && (!r_ov || o_res.ready);

    tpwm_serial_alu #(.W(W)) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_rsp   (w_rsp),
        .o_res   (w_res),
        .o_rem   (w_rem)
    );

    tpwm_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .SINE_BITS        (SINE_BITS)
    ) u_rom (
        .i_clk (i_clk),
        .i_idx (r_phase ? r_idx2 : r_idx1),
        .o_mag (w_rom_mag),
        .o_neg (w_rom_neg)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tpwm_pkg::S_IDLE;
            r_issued <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_rsp.done) begin
                r_issued <= 1'b0;
            end else if (w_req.start) begin
                r_issued <= 1'b1;
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        w_req     = '0;
        w_a       = '0;
        w_b       = '0;
        unique case (r_state)
            tpwm_pkg::S_IDLE: begin
                if (i_item.valid) begin
                    if (!i_item.op) begin
                        n_state = tpwm_pkg::S_TK_START;
                    end else if (i_item.speed_percent == '0) begin
                        n_state = tpwm_pkg::S_SP_END;
                    end else begin
                        n_state = tpwm_pkg::S_SP_MUL1;
                    end
                end
            end
            tpwm_pkg::S_SP_MUL1: begin
                w_req.start = !r_issued;
                w_a = W'(r_max);
                w_b = W'(r_nom);
                if (w_rsp.done) n_state = tpwm_pkg::S_SP_MUL2;
            end
            tpwm_pkg::S_SP_MUL2: begin
                w_req.start = !r_issued;
                w_a = W'(r_max);
                w_b = W'(r_speed);
                if (w_rsp.done) n_state = tpwm_pkg::S_SP_MUL3;
            end
            tpwm_pkg::S_SP_MUL3: begin
                w_req.start = !r_issued;
                w_a = W'(r_nom);
                w_b = W'(r_speed);
                if (w_rsp.done) n_state = tpwm_pkg::S_SP_DIV;
            end
            tpwm_pkg::S_SP_DIV: begin
                w_req.op = tpwm_pkg::ALU_DIV;
                w_a = w_num;
                w_b = w_den_pos - W'(r_z);
                if (!r_issued && w_sp_skip) begin
                    n_state = tpwm_pkg::S_SP_END;
                end else begin
                    w_req.start = !r_issued;
                end
                if (w_rsp.done) n_state = tpwm_pkg::S_SP_END;
            end
            tpwm_pkg::S_SP_END: begin
                n_state = tpwm_pkg::S_DONE;
            end
            tpwm_pkg::S_TK_START: begin
                n_state = (r_target == '0) ? tpwm_pkg::S_DONE : tpwm_pkg::S_TK_FULL;
            end
            tpwm_pkg::S_TK_FULL: begin
                w_req.start = !r_issued;
                w_a = W'(r_active);
                w_b = W'(r_tpm);
                if (w_rsp.done) n_state = tpwm_pkg::S_TK_MOD;
            end
            tpwm_pkg::S_TK_MOD: begin
                w_req.op = tpwm_pkg::ALU_DIV;
                w_a = W'(r_cnt);
                w_b = W'(r_full);
                if (!r_issued) begin
                    if (w_nowrap) begin
                        n_state = tpwm_pkg::S_TK_IDX;
                    end else if (w_full0) begin
                        n_state = tpwm_pkg::S_TK_FULL2;
                    end else begin
                        w_req.start = 1'b1;
                    end
                end
                if (w_rsp.done) n_state = tpwm_pkg::S_TK_FULL2;
            end
            tpwm_pkg::S_TK_FULL2: begin
                w_req.start = !r_issued;
                w_a = W'(r_active);
                w_b = W'(r_tpm);
                if (w_rsp.done) n_state = tpwm_pkg::S_TK_IDX;
            end
            tpwm_pkg::S_TK_IDX: begin
                w_req.op = tpwm_pkg::ALU_DIV;
                w_a = W'({r_cnt[19:0], {DB{1'b0}}});
                w_b = W'(r_full);
                if (!r_issued && w_full0) begin
                    n_state = tpwm_pkg::S_TK_SH;
                end else begin
                    w_req.start = !r_issued;
                end
                if (w_rsp.done) n_state = tpwm_pkg::S_TK_SH;
            end
            tpwm_pkg::S_TK_SH: begin
                w_req.op    = tpwm_pkg::ALU_DIV;
                w_req.start = !r_issued;
                w_a = W'({r_psp, {DB{1'b0}}}) + W'(tpwm_pkg::PCT_ROUND);
                w_b = W'(tpwm_pkg::PCT_SCALE);
                if (w_rsp.done) n_state = tpwm_pkg::S_TK_FL_MUL;
            end
            tpwm_pkg::S_TK_FL_MUL: begin
                w_req.start = !r_issued;
                w_a = W'(r_pwm);
                w_b = W'(r_floor);
                if (w_rsp.done) n_state = tpwm_pkg::S_TK_FL_DIV;
            end
            tpwm_pkg::S_TK_FL_DIV: begin
                w_req.op    = tpwm_pkg::ALU_DIV;
                w_req.start = !r_issued;
                w_a = r_x;
                w_b = W'(tpwm_pkg::PCT_SCALE);
                if (w_rsp.done) n_state = tpwm_pkg::S_TK_ROM;
            end
            tpwm_pkg::S_TK_ROM: begin
                n_state = tpwm_pkg::S_TK_AMP_MUL;
            end
            tpwm_pkg::S_TK_AMP_MUL: begin
                w_req.start = !r_issued;
                w_a = W'(w_rom_mag);
                w_b = W'(w_factor);
                if (w_rsp.done) n_state = tpwm_pkg::S_TK_AMP_DIV;
            end
            tpwm_pkg::S_TK_AMP_DIV: begin
                w_req.op    = tpwm_pkg::ALU_DIV;
                w_req.start = !r_issued;
                w_a = r_x;
                w_b = W'(tpwm_pkg::PERMILLE);
                if (w_rsp.done) n_state = tpwm_pkg::S_TK_C_MUL;
            end
            tpwm_pkg::S_TK_C_MUL: begin
                w_req.start = !r_issued;
                w_a = W'(r_pwm);
                w_b = W'(r_m);
                if (w_rsp.done) n_state = tpwm_pkg::S_TK_C_DIV;
            end
            tpwm_pkg::S_TK_C_DIV: begin
                w_req.op    = tpwm_pkg::ALU_DIV;
                w_req.start = !r_issued;
                w_a = r_x;
                w_b = W'(AMP);
                if (w_rsp.done) n_state = tpwm_pkg::S_TK_V_MUL;
            end
            tpwm_pkg::S_TK_V_MUL: begin
                w_req.start = !r_issued;
                w_a = r_x;
                w_b = W'(r_nom);
                if (w_rsp.done) n_state = tpwm_pkg::S_TK_V_DIV;
            end
            tpwm_pkg::S_TK_V_DIV: begin
                w_req.op    = tpwm_pkg::ALU_DIV;
                w_req.start = !r_issued;
                w_a = r_x;
                w_b = W'(r_active);
                if (w_rsp.done) n_state = tpwm_pkg::S_TK_STORE;
            end
            tpwm_pkg::S_TK_STORE: begin
                n_state = r_phase ? tpwm_pkg::S_DONE : tpwm_pkg::S_TK_ROM;
            end
            tpwm_pkg::S_DONE: begin
                if (!r_ov || o_res.ready) n_state = tpwm_pkg::S_IDLE;
            end
            default: begin
                n_state = tpwm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm   <= tpwm_pkg::PWM_PERIOD_RST;
            r_nom   <= tpwm_pkg::NOM_PERIOD_RST;
            r_min   <= tpwm_pkg::MIN_PERIOD_RST;
            r_max   <= tpwm_pkg::MAX_PERIOD_RST;
            r_psp   <= tpwm_pkg::PHASE_SHIFT_RST;
            r_comp  <= tpwm_pkg::VOLT_COMP_RST;
            r_floor <= tpwm_pkg::FLOOR_PCT_RST;
            r_tpm   <= tpwm_pkg::TICKS_MS_RST;
        end else if (i_cfg_we) begin
            unique case (tpwm_pkg::t_cfg_idx'(i_cfg_idx))
                tpwm_pkg::CFG_PWM_PERIOD:   r_pwm   <= i_cfg_data;
                tpwm_pkg::CFG_NOM_PERIOD:   r_nom   <= i_cfg_data[9:0];
                tpwm_pkg::CFG_MIN_PERIOD:   r_min   <= i_cfg_data[9:0];
                tpwm_pkg::CFG_MAX_PERIOD:   r_max   <= i_cfg_data[9:0];
                tpwm_pkg::CFG_PHASE_SHIFT:  r_psp   <= i_cfg_data[6:0];
                tpwm_pkg::CFG_VOLT_COMP:    r_comp  <= i_cfg_data[9:0];
                tpwm_pkg::CFG_FLOOR_PCT:    r_floor <= i_cfg_data[6:0];
                tpwm_pkg::CFG_TICKS_PER_MS: r_tpm   <= i_cfg_data[9:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
            r_active <= '0;
            r_count  <= '0;
            r_en     <= 1'b0;
            for (int j = 0; j < 4; j++) begin
                r_cmp[j] <= '0;
            end
        end else begin
            case (r_state)
                tpwm_pkg::S_SP_END: begin
                    r_target <= (r_speed == '0) ? 10'd0 : w_per2[9:0];
                    if ((r_speed == '0) || (w_per2[9:0] == '0)) begin
                        r_active <= '0;
                    end
                    r_en <= (r_speed != '0);
                end
                tpwm_pkg::S_TK_START: begin
                    if (r_target == '0) begin
                        r_active <= '0;
                        for (int j = 0; j < 4; j++) begin
                            r_cmp[j] <= '0;
                        end
                    end else if (r_active == '0) begin
                        r_active <= r_target;
                    end
                end
                tpwm_pkg::S_TK_MOD: begin
                    if ((!r_issued && !w_nowrap && w_full0) || w_rsp.done) begin
                        r_active <= r_target;
                    end
                end
                tpwm_pkg::S_TK_IDX: begin
                    r_count <= r_cnt[19:0];
                end
                tpwm_pkg::S_TK_STORE: begin
                    r_cmp[{r_phase, r_neg}]  <= w_cf;
                    r_cmp[{r_phase, ~r_neg}] <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            tpwm_pkg::S_IDLE: begin
                r_op      <= i_item.op;
                r_elapsed <= i_item.elapsed_ticks;
                r_speed   <= i_item.speed_percent;
            end
            tpwm_pkg::S_SP_MUL1: if (w_rsp.done) r_x <= w_res;
            tpwm_pkg::S_SP_MUL2: if (w_rsp.done) r_y <= w_res[17:0];
            tpwm_pkg::S_SP_MUL3: if (w_rsp.done) r_z <= w_res[17:0];
            tpwm_pkg::S_SP_DIV: begin
                if (!r_issued && w_sp_skip) begin
                    r_x <= W'(r_min);
                end else if (w_rsp.done) begin
                    r_x <= w_res;
                end
            end
            tpwm_pkg::S_TK_START: begin
                r_cnt <= (r_active == '0) ? 21'd0 : 21'(r_count) + 21'(r_elapsed);
            end
            tpwm_pkg::S_TK_FULL, tpwm_pkg::S_TK_FULL2: begin
                if (w_rsp.done) r_full <= w_res[19:0];
            end
            tpwm_pkg::S_TK_MOD: begin
                if (!r_issued && !w_nowrap && w_full0) begin
                    r_cnt <= '0;
                end else if (w_rsp.done) begin
                    r_cnt <= w_rem[20:0];
                end
            end
            tpwm_pkg::S_TK_IDX: begin
                if (!r_issued && w_full0) begin
                    r_idx1 <= '0;
                end else if (w_rsp.done) begin
                    r_idx1 <= w_res[DB-1:0];
                end
            end
            tpwm_pkg::S_TK_SH: begin
                if (w_rsp.done) r_idx2 <= r_idx1 - w_res[DB-1:0];
            end
            tpwm_pkg::S_TK_FL_MUL: if (w_rsp.done) r_x <= w_res;
            tpwm_pkg::S_TK_FL_DIV: begin
                r_phase <= 1'b0;
                if (w_rsp.done) r_fl <= w_res[16:0];
            end
            tpwm_pkg::S_TK_AMP_MUL: begin
                if (!r_issued) r_neg <= w_rom_neg;
                if (w_rsp.done) r_x <= w_res;
            end
            tpwm_pkg::S_TK_AMP_DIV: begin
                if (w_rsp.done) r_m <= (w_res > W'(AMP)) ? AMP : w_res[MW-1:0];
            end
            tpwm_pkg::S_TK_C_MUL, tpwm_pkg::S_TK_C_DIV,
            tpwm_pkg::S_TK_V_MUL, tpwm_pkg::S_TK_V_DIV: begin
                if (w_rsp.done) r_x <= w_res;
            end
            tpwm_pkg::S_TK_STORE: r_phase <= 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_out_load) begin
            r_ov <= 1'b1;
        end else if (o_res.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            for (int j = 0; j < 4; j++) begin
                r_o_cmp[j] <= r_cmp[j];
            end
            r_o_en  <= r_en;
            r_o_run <= (r_target != '0);
        end
    end

    assign i_item.ready        = (r_state == tpwm_pkg::S_IDLE);
    assign o_res.valid         = r_ov;
    assign o_res.phase1_pos    = r_o_cmp[0];
    assign o_res.phase1_neg    = r_o_cmp[1];
    assign o_res.phase2_pos    = r_o_cmp[2];
    assign o_res.phase2_neg    = r_o_cmp[3];
    assign o_res.driver_enable = r_o_en;
    assign o_res.running       = r_o_run;

    logic w_unused;
    assign w_unused = r_op;

endmodule

`default_nettype wire

FILE: rtl/tpwm_checker.sv
// Port-level checks on the result channel, bound to the top level.
`default_nettype none

module tpwm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [15:0] i_p1_pos,
    input wire logic [15:0] i_p1_neg,
    input wire logic [15:0] i_p2_pos,
    input wire logic [15:0] i_p2_neg,
    input wire logic        i_drv_en,
    input wire logic        i_running
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_p1_pos)
            && $stable(i_p1_neg) && $stable(i_p2_pos) && $stable(i_p2_neg)
            && $stable(i_drv_en) && $stable(i_running))
        else $error("result word changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word valid after reset");

    a_run_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_running |-> i_drv_en)
        else $error("running without driver enable");

    a_p1_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_p1_pos == 16'd0) || (i_p1_neg == 16'd0))
        else $error("phase one drives both halves");

    a_p2_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_p2_pos == 16'd0) || (i_p2_neg == 16'd0))
        else $error("phase two drives both halves");

endmodule

bind two_phase_vf_sine_pwm tpwm_checker u_tpwm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_p1_pos    (o_res.phase1_pos),
    .i_p1_neg    (o_res.phase1_neg),
    .i_p2_pos    (o_res.phase2_pos),
    .i_p2_neg    (o_res.phase2_neg),
    .i_drv_en    (o_res.driver_enable),
    .i_running   (o_res.running)
);

`default_nettype wire

FILE: bench/two_phase_vf_sine_pwm_tb.sv
// Self-checking testbench for two_phase_vf_sine_pwm: random words against a V/F sine predictor.
`timescale 1ns / 100ps
`default_nettype none

module two_phase_vf_sine_pwm_tb;
    import tpwm_pkg::*;

    localparam int unsigned TABLE_D   = SINE_TABLE_DEPTH_DEF;
    localparam logic [63:0] SINE_FS   = (64'd1 << (SINE_BITS_DEF - 1)) - 64'd1;
    localparam longint      CYCLE_CAP = 4000000;

    typedef struct packed {
        logic                 op;
        logic [ELAPSED_W-1:0] elapsed;
        logic [SPEED_W-1:0]   speed;
    } t_cmd;

    typedef struct packed {
        logic [CMP_W-1:0] p1_pos;
        logic [CMP_W-1:0] p1_neg;
        logic [CMP_W-1:0] p2_pos;
        logic [CMP_W-1:0] p2_neg;
        logic             drv_en;
        logic             running;
    } t_pwm_word;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    tpwm_in_if  cmd_ch ();
    tpwm_out_if pwm_ch ();

    two_phase_vf_sine_pwm dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (cmd_ch.sink),
        .o_res     (pwm_ch.source),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // predictor settings and state
    logic [63:0] m_pwm, m_nom, m_min, m_max, m_shift, m_comp, m_floor, m_tpm;
    logic [63:0] m_target, m_active, m_count;
    logic [15:0] m_hold [4];
    logic        m_enable;

    t_cmd      cmd_queue [$];
    t_pwm_word pwm_expected [$];
    int        mismatches = 0;
    bit        hold_sender = 1'b0;
    longint    cycles = 0;

    function automatic logic [63:0] quarter_wave(input logic [63:0] r);
        logic [63:0] x, x2, term, acc, v;
        x    = HALF_PI_Q30 * r / 64'(TABLE_D);
        x2   = (x * x) >> 30;
        term = x;
        acc  = x;
        for (int k = 1; k <= 7; k++) begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) acc = (term > acc) ? 64'd0 : acc - term;
            else acc = acc + term;
        end
        v = (acc * SINE_FS + (64'd1 << 29)) >> 30;
        return (v > SINE_FS) ? SINE_FS : v;
    endfunction

    function automatic logic [15:0] scale_compare(input logic [63:0] mag);
        logic [63:0] c, fl;
        c  = m_pwm * mag / SINE_FS;
        fl = m_pwm * m_floor / 64'(PCT_SCALE);
        c  = c * m_nom / m_active;
        if (c > m_pwm) c = m_pwm;
        if (c < fl) c = 0;
        return c[15:0];
    endfunction

    task automatic phase_compare(input logic [63:0] idx, input logic [63:0] gain,
                                 output logic [15:0] pos, output logic [15:0] neg);
        logic [63:0] u, q, r, mag;
        logic        is_neg;
        u = 64'd4 * (idx % TABLE_D);
        q = u / TABLE_D;
        r = u % TABLE_D;
        if (q[0]) r = TABLE_D - r;
        mag = quarter_wave(r);
        is_neg = (q >= 2) && (mag != 0);
        mag = mag * gain / 64'(PERMILLE);
        if (mag > SINE_FS) mag = SINE_FS;
        pos = (!is_neg && mag != 0) ? scale_compare(mag) : 16'd0;
        neg = is_neg ? scale_compare(mag) : 16'd0;
    endtask

    task automatic advance_wave(input logic [63:0] elapsed);
        logic [63:0] cnt, full, idx1, idx2, sh, g2;
        if (m_target == 0) begin
            m_active = 0;
            for (int j = 0; j < 4; j++) m_hold[j] = 0;
            return;
        end
        if (m_active == 0) begin
            m_active = m_target;
            cnt = 0;
        end else begin
            cnt = m_count + elapsed;
        end
        full = m_active * m_tpm;
        if (cnt >= full) begin
            cnt = (full == 0) ? 64'd0 : cnt % full;
            m_active = m_target;
            full = m_active * m_tpm;
        end
        m_count = cnt & 64'hFFFFF;
        idx1 = (full == 0) ? 64'd0 : (m_count * TABLE_D / full) % TABLE_D;
        sh   = ((64'(TABLE_D) * m_shift + PCT_ROUND) / PCT_SCALE) % TABLE_D;
        idx2 = (idx1 + TABLE_D - sh) % TABLE_D;
        g2   = (m_comp >= PERMILLE) ? 64'd0 : 64'(PERMILLE) - m_comp;
        phase_compare(idx1, 64'(PERMILLE) + m_comp, m_hold[0], m_hold[1]);
        phase_compare(idx2, g2, m_hold[2], m_hold[3]);
    endtask

    task automatic set_speed(input logic [63:0] p);
        longint nom, mx, den;
        logic [63:0] per;
        per = 0;
        if (p > 0) begin
            nom = longint'(m_nom);
            mx  = longint'(m_max);
            den = nom * (100 - longint'(p)) + mx * longint'(p);
            if (den <= 0) per = m_min;
            else per = 64'((100 * mx * nom) / den);
            if (per < m_min) per = m_min;
            if (per > m_max) per = m_max;
        end
        m_target = per & 64'h3FF;
        if (m_target == 0) m_active = 0;
        m_enable = (p > 0);
    endtask

    task automatic predict_word(input t_cmd c);
        t_pwm_word w;
        if (c.op) set_speed(64'(c.speed));
        else advance_wave(64'(c.elapsed));
        w.p1_pos  = m_hold[0];
        w.p1_neg  = m_hold[1];
        w.p2_pos  = m_hold[2];
        w.p2_neg  = m_hold[3];
        w.drv_en  = m_enable;
        w.running = (m_target != 0);
        pwm_expected.push_back(w);
    endtask

    // sender: bursts with gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else begin
            if (cmd_ch.valid && cmd_ch.ready) begin
                predict_word('{cmd_ch.op, cmd_ch.elapsed_ticks, cmd_ch.speed_percent});
            end
            if (!cmd_ch.valid || cmd_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    cmd_ch.valid <= 1'b0;
                end else if (cmd_queue.size() > 0 && !hold_sender) begin
                    t_cmd c;
                    c = cmd_queue.pop_front();
                    cmd_ch.valid         <= 1'b1;
                    cmd_ch.op            <= c.op;
                    cmd_ch.elapsed_ticks <= c.elapsed;
                    cmd_ch.speed_percent <= c.speed;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern, check against oldest expectation
    int stall_phase = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("Some tests failed");
            $finish;
        end
        if (!i_rst_n) begin
            pwm_ch.ready <= 1'b0;
        end else begin
            stall_phase <= (stall_phase + 1) % 97;
            pwm_ch.ready <= (stall_phase < 40) ? 1'b1 :
                            (stall_phase < 70) ? ($urandom_range(0, 2) != 0) :
                            ($urandom_range(0, 5) == 0);
            if (pwm_ch.valid && pwm_ch.ready) begin
                t_pwm_word got, want;
                got = '{pwm_ch.phase1_pos, pwm_ch.phase1_neg, pwm_ch.phase2_pos,
                        pwm_ch.phase2_neg, pwm_ch.driver_enable, pwm_ch.running};
                if (pwm_expected.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected word %p", got);
                end else begin
                    want = pwm_expected.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
                    end
                end
            end
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [63:0] value);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        case (idx)
            CFG_PWM_PERIOD:   m_pwm   = value & 64'hFFFF;
            CFG_NOM_PERIOD:   m_nom   = value & 64'h3FF;
            CFG_MIN_PERIOD:   m_min   = value & 64'h3FF;
            CFG_MAX_PERIOD:   m_max   = value & 64'h3FF;
            CFG_PHASE_SHIFT:  m_shift = value & 64'h7F;
            CFG_VOLT_COMP:    m_comp  = value & 64'h3FF;
            CFG_FLOOR_PCT:    m_floor = value & 64'h7F;
            CFG_TICKS_PER_MS: m_tpm   = value & 64'h3FF;
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_all(input int pwm, input int nom, input int mn, input int mx,
                           input int sh, input int comp, input int fl, input int tpm);
        write_reg(CFG_PWM_PERIOD, pwm);
        write_reg(CFG_NOM_PERIOD, nom);
        write_reg(CFG_MIN_PERIOD, mn);
        write_reg(CFG_MAX_PERIOD, mx);
        write_reg(CFG_PHASE_SHIFT, sh);
        write_reg(CFG_VOLT_COMP, comp);
        write_reg(CFG_FLOOR_PCT, fl);
        write_reg(CFG_TICKS_PER_MS, tpm);
    endtask

    task automatic wait_idle();
        while (cmd_queue.size() > 0 || cmd_ch.valid || pwm_expected.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic t_cmd random_cmd();
        t_cmd c;
        int   r;
        c.elapsed = $urandom;
        c.speed   = $urandom;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            c.op = 1'b1;
            r = $urandom_range(0, 9);
            c.speed = (r == 0) ? 8'd0 : (r < 7) ? 8'($urandom_range(1, 100)) :
                      8'($urandom_range(0, 255));
        end else begin
            c.op = 1'b0;
            r = $urandom_range(0, 3);
            c.elapsed = (r == 0) ? 16'($urandom_range(0, 300)) :
                        (r == 1) ? 16'($urandom_range(0, 3000)) : 16'($urandom);
        end
        return c;
    endfunction

    task automatic push_random(input int n);
        repeat (n) cmd_queue.push_back(random_cmd());
    endtask

    initial begin
        cmd_ch.valid = 1'b0;
        cmd_ch.op = 1'b0;
        cmd_ch.elapsed_ticks = '0;
        cmd_ch.speed_percent = '0;
        pwm_ch.ready = 1'b0;
        m_pwm = PWM_PERIOD_RST;   m_nom = NOM_PERIOD_RST;
        m_min = MIN_PERIOD_RST;   m_max = MAX_PERIOD_RST;
        m_shift = PHASE_SHIFT_RST; m_comp = VOLT_COMP_RST;
        m_floor = FLOOR_PCT_RST;  m_tpm = TICKS_MS_RST;
        m_target = 0; m_active = 0; m_count = 0; m_enable = 0;
        for (int j = 0; j < 4; j++) m_hold[j] = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: off tick, speed extremes, elapsed extremes, cycle wraps
        cmd_queue.push_back('{1'b0, 16'd100, 8'd0});
        cmd_queue.push_back('{1'b1, 16'd0, 8'd0});
        cmd_queue.push_back('{1'b0, 16'hFFFF, 8'hFF});
        cmd_queue.push_back('{1'b1, 16'hFFFF, 8'd100});
        cmd_queue.push_back('{1'b0, 16'd0, 8'd0});
        cmd_queue.push_back('{1'b0, 16'd280, 8'd0});
        cmd_queue.push_back('{1'b0, 16'd560, 8'd0});
        cmd_queue.push_back('{1'b0, 16'hFFFF, 8'd0});
        cmd_queue.push_back('{1'b1, 16'd0, 8'd1});
        cmd_queue.push_back('{1'b0, 16'd1000, 8'd0});
        cmd_queue.push_back('{1'b1, 16'd0, 8'd255});
        cmd_queue.push_back('{1'b0, 16'd30000, 8'd0});
        cmd_queue.push_back('{1'b0, 16'd1, 8'd0});
        cmd_queue.push_back('{1'b1, 16'd0, 8'd50});
        cmd_queue.push_back('{1'b0, 16'd5000, 8'd0});
        cmd_queue.push_back('{1'b1, 16'd0, 8'd0});
        cmd_queue.push_back('{1'b0, 16'd7, 8'd0});
        cmd_queue.push_back('{1'b1, 16'd0, 8'd150});
        cmd_queue.push_back('{1'b0, 16'd0, 8'd0});
        cmd_queue.push_back('{1'b0, 16'd20000, 8'd0});
        push_random(180);
        wait_idle();

        set_all(65535, 1000, 1, 1000, 0, 999, 0, 1);
        cmd_queue.push_back('{1'b1, 16'd0, 8'd100});
        push_random(120);
        // hold the sender until every word is back, then resume
        hold_sender = 1'b1;
        while (pwm_expected.size() > 0 || cmd_ch.valid) @(posedge i_clk);
        hold_sender = 1'b0;
        wait_idle();

        set_all(1, 1, 1000, 1000, 100, 0, 100, 1000);
        cmd_queue.push_back('{1'b1, 16'd0, 8'd80});
        push_random(100);
        wait_idle();

        set_all($urandom_range(1, 65535), $urandom_range(1, 1000), $urandom_range(1, 100),
                $urandom_range(100, 1000), $urandom_range(0, 100), $urandom_range(0, 999),
                $urandom_range(0, 10), $urandom_range(1, 100));
        push_random(150);
        wait_idle();

        // inverted limits and negative denominators above full speed
        set_all(8400, 900, 500, 14, 50, 500, 2, 3);
        cmd_queue.push_back('{1'b1, 16'd0, 8'd255});
        push_random(120);
        wait_idle();

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
